### design/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 stream transcoder.
// No dependencies; imported by every module of the block.
package u8u16_pkg;

    localparam int unsigned CP_W   = 21;   // code point width
    localparam int unsigned UNIT_W = 16;   // UTF-16 code unit width

    localparam logic [7:0]        CONT_MASK   = 8'h3F;
    localparam logic [7:0]        LEAD2_MASK  = 8'h1F;
    localparam logic [7:0]        LEAD3_MASK  = 8'h0F;
    localparam logic [7:0]        LEAD4_MASK  = 8'h07;
    localparam logic [CP_W-1:0]   PLANE1_BASE = 21'h10000;
    localparam logic [UNIT_W-1:0] HI_SURR     = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR     = 16'hDC00;
    localparam logic [9:0]        SURR_MASK   = 10'h3FF;

    // Count of continuation bytes still due
    typedef enum logic [1:0] {
        LEFT_NONE  = 2'd0,
        LEFT_ONE   = 2'd1,
        LEFT_TWO   = 2'd2,
        LEFT_THREE = 2'd3
    } t_left;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              run_last;
        logic              string_done;
    } t_out_item;

    // One finished code point handed from the decoder to the emitter
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            end_of_string;
    } t_event;

endpackage

### design/u8u16_decode.sv
// Byte decoder: holds the partial code point and the pending byte count.
// Depends on u8u16_pkg.
module u8u16_decode import u8u16_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,     // input transaction this cycle
    input  t_in_item i_item,
    output logic     o_fire,     // a code point completes with this byte
    output t_event   o_event
);

    logic [CP_W-1:0] r_point, n_point;
    t_left           r_left,  n_left;

    // Lead or continuation decode
    always_comb begin
        if (r_left == LEFT_NONE) begin
            if (!i_item.data_byte[7]) begin
                n_point = CP_W'(i_item.data_byte);
                n_left  = LEFT_NONE;
            end else if (i_item.data_byte[7:5] != 3'b111) begin
                n_point = CP_W'(i_item.data_byte & LEAD2_MASK);
                n_left  = LEFT_ONE;
            end else if (!i_item.data_byte[4]) begin
                n_point = CP_W'(i_item.data_byte & LEAD3_MASK);
                n_left  = LEFT_TWO;
            end else begin
                n_point = CP_W'(i_item.data_byte & LEAD4_MASK);
                n_left  = LEFT_THREE;
            end
        end else begin
            n_point = {r_point[CP_W-7:0], i_item.data_byte[5:0] & CONT_MASK[5:0]};
            n_left  = t_left'(r_left - 2'd1);
        end
    end

    assign o_fire                = (n_left == LEFT_NONE) || i_item.end_of_string;
    assign o_event.code_point    = n_point;
    assign o_event.end_of_string = i_item.end_of_string;

    // State update; a finished or cut-short sequence returns to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point <= '0;
            r_left  <= LEFT_NONE;
        end else if (i_take) begin
            if (o_fire) begin
                r_point <= '0;
                r_left  <= LEFT_NONE;
            end else begin
                r_point <= n_point;
                r_left  <= n_left;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_fire) |=> (r_left == LEFT_NONE && r_point == '0))
        else $error("decoder state not cleared after a completed code point");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left == LEFT_NONE) |-> (r_point == '0))
        else $error("partial code point held with no sequence open");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_take |=> (r_left == $past(r_left) && r_point == $past(r_point)))
        else $error("decoder state moved without an input transaction");

endmodule

### design/u8u16_emit.sv
// Result register and surrogate splitter: turns one code point into one or two units.
// Depends on u8u16_pkg.
module u8u16_emit import u8u16_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,        // decoder hands over a code point
    input  t_event    i_event,
    output logic      o_load_ready,  // room for a code point this cycle
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic            r_full;
    logic            r_hi_phase;     // high surrogate is on the output
    logic [CP_W-1:0] r_point;
    logic            r_eos;

    logic              pair;
    logic              take;
    logic [CP_W-1:0]   w;
    logic [UNIT_W-1:0] hi_unit;
    logic [UNIT_W-1:0] lo_unit;

    assign pair    = (r_point[CP_W-1:UNIT_W] != '0);
    assign take    = o_valid && i_ready;
    assign w       = r_point - PLANE1_BASE;
    assign hi_unit = HI_SURR + UNIT_W'(w[CP_W-1:10]);
    assign lo_unit = LO_SURR | UNIT_W'(w[9:0] & SURR_MASK);

    assign o_valid      = r_full;
    assign o_load_ready = !r_full || (take && !r_hi_phase);

    // Output unit select
    always_comb begin
        if (r_hi_phase) begin
            o_item.code_unit   = hi_unit;
            o_item.run_last    = 1'b0;
            o_item.string_done = 1'b0;
        end else begin
            o_item.code_unit   = pair ? lo_unit : r_point[UNIT_W-1:0];
            o_item.run_last    = 1'b1;
            o_item.string_done = r_eos;
        end
    end

    // Control: full flag and surrogate phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full     <= 1'b0;
            r_hi_phase <= 1'b0;
        end else if (i_load && o_load_ready) begin
            r_full     <= 1'b1;
            r_hi_phase <= (i_event.code_point[CP_W-1:UNIT_W] != '0);
        end else if (take) begin
            if (r_hi_phase) begin
                r_hi_phase <= 1'b0;
            end else begin
                r_full <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load && o_load_ready) begin
            r_point <= i_event.code_point;
            r_eos   <= i_event.end_of_string;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hi_phase |-> r_full)
        else $error("surrogate phase set with empty result register");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_hi_phase) |=> (r_full && !r_hi_phase && pair))
        else $error("low surrogate did not follow high surrogate");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_load_ready)
        else $error("code point delivered with no room in result register");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.string_done) |-> o_item.run_last)
        else $error("end of string flagged on a non-final unit");

endmodule

### design/utf8_to_utf16_stream_top.sv
// Top level of the UTF-8 to UTF-16 stream transcoder.
// Depends on u8u16_pkg, u8u16_decode and u8u16_emit.
//
// Takes one UTF-8 byte per transaction and produces UTF-16 code units. A byte
// is decoded in the cycle it is accepted, against the held partial code point,
// and a finished code point lands in a one-entry result register the next
// cycle. A byte that leaves a sequence open produces nothing; a code point
// below 0x10000 produces one unit, and a larger one a high then a low
// surrogate. Input ready is high whenever the result register is empty or
// its last unit is taken in that cycle, so bytes flow one per clock while a
// unit per code point suffices and the output is not stalled; no byte is
// taken while the high surrogate of a pair is on the output. No validation
// is done; a sequence cut by end_of_string emits the value built so far.
module utf8_to_utf16_stream_top import u8u16_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic   take;
    logic   fire;
    t_event event_q;

    assign take = i_in_valid && o_in_ready;

    u8u16_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_in_item),
        .o_fire  (fire),
        .o_event (event_q)
    );

    u8u16_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (take && fire),
        .i_event      (event_q),
        .o_load_ready (o_in_ready),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_item       (o_out_item)
    );

endmodule
